[sv/pip_pkg.sv]
// Shared types and constants for the point-in-polygon crossing-number core.
`timescale 1ns / 1ps

package pip_pkg;

	// width of the reported crossing distance
	localparam int DIST_W = 32;

	// sequencer states for one edge request
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NUDGE,
		ST_DIFF,
		ST_MAG,
		ST_MUL,
		ST_DIV,
		ST_XC,
		ST_FIN
	} pip_state_t;

	// stage enables from the sequencer to the datapath
	typedef struct packed {
		logic cap;
		logic nudge;
		logic diff;
		logic mag;
		logic mul;
		logic div;
	} pip_ctrl_t;

endpackage

[sv/pip_prep.sv]
// Edge preprocessing: capture, vertex nudge, straddle test, differences and magnitudes.
`timescale 1ns / 1ps

module pip_prep import pip_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  pip_ctrl_t                    ctrl,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	input  logic signed [COORD_BITS-1:0] edge_x0,
	input  logic signed [COORD_BITS-1:0] edge_y0,
	input  logic signed [COORD_BITS-1:0] edge_x1,
	input  logic signed [COORD_BITS-1:0] edge_y1,
	input  logic                         last_edge,
	output logic signed [COORD_BITS-1:0] qx,
	output logic signed [COORD_BITS-1:0] x0,
	output logic                         last,
	output logic                         straddle,
	output logic                         neg,
	output logic        [COORD_BITS-1:0] mag_dx,
	output logic        [COORD_BITS:0]   mag_t,
	output logic        [COORD_BITS:0]   mag_dy
);

	localparam int N = COORD_BITS;

	logic signed [N-1:0] qx_q, qy_q, x0_q, y0_q, x1_q, y1_q;
	logic                last_q;
	logic signed [N:0]   y0n_q, y1n_q, dx_q;
	logic signed [N+1:0] t_q, dy_q;
	logic                straddle_q, neg_q;

	logic signed [N:0]   qy_e, y0_e, y1_e, qy_inc;
	logic                below0, below1, above0, above1;
	logic [N:0]          dx_abs;
	logic [N+1:0]        t_abs, dy_abs;

	// hold the request fields
	always_ff @(posedge clk) begin
		if (ctrl.cap) begin
			qx_q   <= query_x;
			qy_q   <= query_y;
			x0_q   <= edge_x0;
			y0_q   <= edge_y0;
			x1_q   <= edge_x1;
			y1_q   <= edge_y1;
			last_q <= last_edge;
		end
	end

	// raise a vertex lying on the ray by one LSB
	always_comb begin
		qy_e   = {qy_q[N-1], qy_q};
		y0_e   = {y0_q[N-1], y0_q};
		y1_e   = {y1_q[N-1], y1_q};
		qy_inc = qy_e + (N+1)'(1);
	end

	always_ff @(posedge clk) begin
		if (ctrl.nudge) begin
			y0n_q <= (y0_q == qy_q) ? qy_inc : y0_e;
			y1n_q <= (y1_q == qy_q) ? qy_inc : y1_e;
			dx_q  <= {x1_q[N-1], x1_q} - {x0_q[N-1], x0_q};
		end
	end

	// test straddle and form signed differences
	always_comb begin
		below0 = y0n_q < qy_e;
		below1 = y1n_q < qy_e;
		above0 = y0n_q > qy_e;
		above1 = y1n_q > qy_e;
	end

	always_ff @(posedge clk) begin
		if (ctrl.diff) begin
			straddle_q <= !((below0 && below1) || (above0 && above1));
			t_q        <= {qy_e[N], qy_e} - {y0n_q[N], y0n_q};
			dy_q       <= {y1n_q[N], y1n_q} - {y0n_q[N], y0n_q};
		end
	end

	// take magnitudes; the sign of the quotient is the xor of the three signs
	always_comb begin
		dx_abs = dx_q[N] ? (~dx_q + (N+1)'(1)) : dx_q;
		t_abs  = t_q[N+1] ? (~t_q + (N+2)'(1)) : t_q;
		dy_abs = dy_q[N+1] ? (~dy_q + (N+2)'(1)) : dy_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.mag) begin
			neg_q <= dx_q[N] ^ t_q[N+1] ^ dy_q[N+1];
		end
	end

	assign qx       = qx_q;
	assign x0       = x0_q;
	assign last     = last_q;
	assign straddle = straddle_q;
	assign neg      = neg_q;
	assign mag_dx   = dx_abs[N-1:0];
	assign mag_t    = t_abs[N:0];
	assign mag_dy   = dy_abs[N:0];

endmodule

[sv/pip_muldiv.sv]
// Bit-serial shift-add multiplier and restoring divider sharing one shift register.
`timescale 1ns / 1ps

module pip_muldiv import pip_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                  clk,
	input  pip_ctrl_t             ctrl,
	input  logic [COORD_BITS-1:0] mag_dx,
	input  logic [COORD_BITS:0]   mag_t,
	input  logic [COORD_BITS:0]   mag_dy,
	output logic [COORD_BITS-1:0] quot
);

	localparam int N = COORD_BITS;

	// product / remainder high part and multiplier / quotient low part
	logic [N+1:0] hi_q;
	logic [N-1:0] lo_q;
	logic [N:0]   mt_q, d_q;

	logic [N+1:0] sum, r2, rdiff;
	logic         ge;

	always_comb begin
		sum   = hi_q + {1'b0, (lo_q[0] ? mt_q : '0)};
		r2    = {hi_q[N:0], lo_q[N-1]};
		rdiff = r2 - {1'b0, d_q};
		ge    = r2 >= {1'b0, d_q};
	end

	// load operands, then add-and-shift right, then compare-and-shift left
	always_ff @(posedge clk) begin
		if (ctrl.mag) begin
			hi_q <= '0;
			lo_q <= mag_dx;
			mt_q <= mag_t;
			d_q  <= mag_dy;
		end else if (ctrl.mul) begin
			hi_q <= {1'b0, sum[N+1:1]};
			lo_q <= {sum[0], lo_q[N-1:1]};
		end else if (ctrl.div) begin
			hi_q <= ge ? rdiff : r2;
			lo_q <= {lo_q[N-2:0], ge};
		end
	end

	assign quot = lo_q;

endmodule

[sv/point_in_polygon_ray_cast_core.sv]
// Top level of the crossing-number point-in-polygon core: sequencer and parity/distance state.
//
// Usage: send the boundary edges of one polygon as requests on the input
// channel (in_valid / in_stall), each with the query point, and last_edge set
// on the final edge. After that edge one result appears on the output channel
// (out_valid / out_stall): inside_res (odd crossing count at or right of the point),
// any_crossing, and min_distance (least x distance to a crossing, all ones if none).
// The block works on one edge at a time. An edge whose ends lie on one side of
// the query y passes the nudge, difference, magnitude and finish states; an
// edge that straddles it also runs the bit-serial multiply and the bit-serial
// restoring divide, one bit per cycle each, through one shared shift register.
// The result of the last edge is registered; the next polygon's edges are taken
// while it waits. If the result is still stalled when the next last edge
// finishes, that edge holds in its final cycle until the output is taken.
// Reset clears parity, crossing flag, distance (to all ones), the sequencer and
// the output valid.
`timescale 1ns / 1ps

module point_in_polygon_ray_cast_core import pip_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	input  logic signed [COORD_BITS-1:0] edge_x0,
	input  logic signed [COORD_BITS-1:0] edge_y0,
	input  logic signed [COORD_BITS-1:0] edge_x1,
	input  logic signed [COORD_BITS-1:0] edge_y1,
	input  logic                         last_edge,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         inside_res,
	output logic                         any_crossing,
	output logic        [DIST_W-1:0]     min_distance
);

	localparam int N  = COORD_BITS;
	localparam int DW = COORD_BITS + 1;
	localparam int CW = $clog2(COORD_BITS);

	pip_state_t state_q, state_d;
	pip_ctrl_t  ctrl;
	logic [CW-1:0] cnt_q;
	logic          cnt_last;

	logic signed [N-1:0] qx, x0;
	logic                last, straddle, neg;
	logic [N-1:0]        mag_dx, quot;
	logic [N:0]          mag_t, mag_dy;

	logic signed [N+1:0] xc_q;
	logic                par_q, seen_q;
	logic [DIST_W-1:0]   best_q;
	logic                out_valid_q, inside_q, any_q;
	logic [DIST_W-1:0]   min_q;

	logic [N+1:0]        x0_e, q_e, qx_e, dist_full;
	logic [DW-1:0]       dist_lo;
	logic                sat, crossing, fin_ok, fin_go;
	logic [DIST_W-1:0]   d32, best_new;
	logic                par_new, seen_new;

	pip_prep #(.COORD_BITS(COORD_BITS)) u_prep (
		.clk       (clk),
		.ctrl      (ctrl),
		.query_x   (query_x),
		.query_y   (query_y),
		.edge_x0   (edge_x0),
		.edge_y0   (edge_y0),
		.edge_x1   (edge_x1),
		.edge_y1   (edge_y1),
		.last_edge (last_edge),
		.qx        (qx),
		.x0        (x0),
		.last      (last),
		.straddle  (straddle),
		.neg       (neg),
		.mag_dx    (mag_dx),
		.mag_t     (mag_t),
		.mag_dy    (mag_dy)
	);

	pip_muldiv #(.COORD_BITS(COORD_BITS)) u_muldiv (
		.clk    (clk),
		.ctrl   (ctrl),
		.mag_dx (mag_dx),
		.mag_t  (mag_t),
		.mag_dy (mag_dy),
		.quot   (quot)
	);

	assign cnt_last = cnt_q == CW'(N - 1);
	assign fin_ok   = !last || !out_valid_q || !out_stall;
	assign fin_go   = (state_q == ST_FIN) && fin_ok;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_NUDGE;
			ST_NUDGE: state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_MAG;
			ST_MAG:   state_d = straddle ? ST_MUL : ST_FIN;
			ST_MUL:   if (cnt_last) state_d = ST_DIV;
			ST_DIV:   if (cnt_last) state_d = ST_XC;
			ST_XC:    state_d = ST_FIN;
			ST_FIN:   if (fin_ok) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// stage enables
	always_comb begin
		ctrl       = '0;
		ctrl.cap   = (state_q == ST_IDLE) && in_valid;
		ctrl.nudge = state_q == ST_NUDGE;
		ctrl.diff  = state_q == ST_DIFF;
		ctrl.mag   = state_q == ST_MAG;
		ctrl.mul   = state_q == ST_MUL;
		ctrl.div   = state_q == ST_DIV;
	end

	assign in_stall = state_q != ST_IDLE;

	// advance sequencer and bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.mag || ((ctrl.mul || ctrl.div) && cnt_last)) begin
				cnt_q <= '0;
			end else if (ctrl.mul || ctrl.div) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// form crossing x from start vertex and signed quotient
	always_comb begin
		x0_e = {{2{x0[N-1]}}, x0};
		q_e  = {2'b00, quot};
		qx_e = {{2{qx[N-1]}}, qx};
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_XC) begin
			xc_q <= neg ? (x0_e - q_e) : (x0_e + q_e);
		end
	end

	// distance, saturation and running minimum
	always_comb begin
		dist_full = xc_q - qx_e;
		dist_lo   = dist_full[DW-1:0];
		crossing  = straddle && !dist_full[N+1];
		sat       = dist_lo > DW'(32'hFFFF_FFFF);
		d32       = sat ? '1 : DIST_W'(dist_lo);
		par_new   = par_q ^ crossing;
		seen_new  = seen_q | crossing;
		best_new  = (crossing && (d32 < best_q)) ? d32 : best_q;
	end

	// update running state; clear it after the last edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q  <= 1'b0;
			seen_q <= 1'b0;
			best_q <= '1;
		end else if (fin_go) begin
			if (last) begin
				par_q  <= 1'b0;
				seen_q <= 1'b0;
				best_q <= '1;
			end else begin
				par_q  <= par_new;
				seen_q <= seen_new;
				best_q <= best_new;
			end
		end
	end

	// hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go && last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go && last) begin
			inside_q <= par_new;
			any_q    <= seen_new;
			min_q    <= best_new;
		end
	end

	assign out_valid    = out_valid_q;
	assign inside_res   = inside_q;
	assign any_crossing = any_q;
	assign min_distance = min_q;

endmodule

[test/tb_top.sv]
// Self-checking testbench for point_in_polygon_ray_cast_core: random and directed edge streams.
`timescale 1ns / 1ps

module tb_top import pip_pkg::*;;

	localparam int CW        = 32;
	localparam int ITEMS     = 1850;
	localparam int IDLE_PCT  = 37;
	localparam int LIMIT     = 1000000;
	localparam int QUIET_LO  = 20000;
	localparam int QUIET_HI  = 35000;
	localparam int HOLD_AT   = 5000;
	localparam int HOLD_LEN  = 1500;
	localparam int DRAIN     = 200;
	localparam int MAX_SHOWN = 100;

	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

	typedef struct {
		logic signed [CW-1:0] qx;
		logic signed [CW-1:0] qy;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic                 last;
	} edge_req_t;

	typedef struct {
		logic              odd;
		logic              hit;
		logic [DIST_W-1:0] dist_val;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [CW-1:0] query_x = '0;
	logic signed [CW-1:0] query_y = '0;
	logic signed [CW-1:0] edge_x0 = '0;
	logic signed [CW-1:0] edge_y0 = '0;
	logic signed [CW-1:0] edge_x1 = '0;
	logic signed [CW-1:0] edge_y1 = '0;
	logic                 last_edge = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 inside_res;
	logic                 any_crossing;
	logic [DIST_W-1:0]    min_distance;

	edge_req_t edge_reqs[$];
	verdict_t  verdicts_due[$];
	edge_req_t on_wire;

	// crossing state of the polygon being traced
	logic              ray_odd = 1'b0;
	logic              ray_hit = 1'b0;
	logic [DIST_W-1:0] ray_best = '1;

	int cyc = 0;
	int errors = 0;
	int hold_left = 0;
	logic quiet;

	assign quiet = cyc >= QUIET_LO && cyc < QUIET_HI;

	point_in_polygon_ray_cast_core #(
		.COORD_BITS(CW)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.query_x     (query_x),
		.query_y     (query_y),
		.edge_x0     (edge_x0),
		.edge_y0     (edge_y0),
		.edge_x1     (edge_x1),
		.edge_y1     (edge_y1),
		.last_edge   (last_edge),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.inside_res  (inside_res),
		.any_crossing(any_crossing),
		.min_distance(min_distance)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("mismatch at cycle %0d: %s", cyc, msg);
	endtask

	// Trace one edge against the ray toward +x; emit a verdict on the last edge.
	function automatic void cross_ray(edge_req_t r);
		longint qx, qy, x0, y0, x1, y1, dx, t, dy, xc, gap;
		logic [63:0] mdx, mt, mdy;
		logic [127:0] prod, quo;
		logic neg;
		logic [DIST_W-1:0] d32;
		verdict_t v;
		qx = longint'(r.qx);
		qy = longint'(r.qy);
		x0 = longint'(r.x0);
		y0 = longint'(r.y0);
		x1 = longint'(r.x1);
		y1 = longint'(r.y1);
		// lift vertices off the ray, wide so the top of range does not wrap
		if (y0 == qy)
			y0 = qy + 1;
		if (y1 == qy)
			y1 = qy + 1;
		if (!((y0 < qy && y1 < qy) || (y0 > qy && y1 > qy))) begin
			dx = x1 - x0;
			t = qy - y0;
			dy = y1 - y0;
			mdx = dx < 0 ? -dx : dx;
			mt = t < 0 ? -t : t;
			mdy = dy < 0 ? -dy : dy;
			prod = {64'd0, mdx} * {64'd0, mt};
			quo = prod / {64'd0, mdy};
			neg = ((dx < 0) != (t < 0)) != (dy < 0);
			if (dx == 0 || t == 0)
				neg = 1'b0;
			xc = neg ? x0 - longint'(quo[63:0]) : x0 + longint'(quo[63:0]);
			// count crossings at or right of the point
			if (xc >= qx) begin
				gap = xc - qx;
				d32 = gap[63:32] != 0 ? '1 : gap[DIST_W-1:0];
				ray_odd = ~ray_odd;
				ray_hit = 1'b1;
				if (d32 < ray_best)
					ray_best = d32;
			end
		end
		if (r.last) begin
			v.odd = ray_odd;
			v.hit = ray_hit;
			v.dist_val = ray_hit ? ray_best : '1;
			verdicts_due.push_back(v);
			ray_odd = 1'b0;
			ray_hit = 1'b0;
			ray_best = '1;
		end
	endfunction

	function automatic void add_edge(int qx, int qy, int x0, int y0, int x1, int y1, int last);
		edge_req_t r;
		r.qx = qx;
		r.qy = qy;
		r.x0 = x0;
		r.y0 = y0;
		r.x1 = x1;
		r.y1 = y1;
		r.last = last != 0;
		edge_reqs.push_back(r);
	endfunction

	function automatic int wild_coord();
		case ($urandom_range(7))
			0: return C_MIN;
			1: return C_MAX;
			2: return 0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	// Build one closed boundary, small or full-range, with the point often on a vertex y.
	function automatic void add_polygon();
		int n, span, bx, by, qx, qy, k, mode;
		int px[8];
		int py[8];
		n = $urandom_range(8, 3);
		mode = $urandom_range(9);
		bx = $urandom;
		by = $urandom;
		span = mode == 9 ? 3 : $urandom_range(1000, 8);
		for (k = 0; k < n; k++) begin
			if (mode >= 6 && mode <= 8) begin
				px[k] = $urandom;
				py[k] = $urandom;
			end else begin
				px[k] = bx + int'($urandom_range(2 * span)) - span;
				py[k] = by + int'($urandom_range(2 * span)) - span;
			end
		end
		if (mode >= 6 && mode <= 8) begin
			qx = $urandom_range(3) == 0 ? px[$urandom_range(n - 1)] : $urandom;
			qy = $urandom;
		end else begin
			qx = bx + int'($urandom_range(2 * span)) - span;
			qy = by + int'($urandom_range(2 * span)) - span;
		end
		if ($urandom_range(2) == 0)
			qy = py[$urandom_range(n - 1)];
		for (k = 0; k < n; k++)
			add_edge(qx, qy, px[k], py[k], px[(k + 1) % n], py[(k + 1) % n],
				int'(k == n - 1));
	endfunction

	// Loose edges with no shared point and random end marks.
	function automatic void add_noise();
		int n, k;
		n = $urandom_range(4, 1);
		for (k = 0; k < n; k++)
			add_edge(wild_coord(), wild_coord(), wild_coord(), wild_coord(),
				wild_coord(), wild_coord(), int'($urandom_range(1)));
	endfunction

	// Count cycles and stop a hung run.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("FAIL point_in_polygon_ray_cast_core");
			$finish;
		end
	end

	// Hold off the output for a long stretch so the core backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (cyc == HOLD_AT)
			hold_left <= HOLD_LEN;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Stall results at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= hold_left != 0 || (!quiet && $urandom_range(99) < IDLE_PCT);
	end

	// Offer edge requests; predict each one as it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				cross_ray(on_wire);
			if (!in_valid || !in_stall) begin
				if (edge_reqs.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
					on_wire = edge_reqs.pop_front();
					query_x <= on_wire.qx;
					query_y <= on_wire.qy;
					edge_x0 <= on_wire.x0;
					edge_y0 <= on_wire.y0;
					edge_x1 <= on_wire.x1;
					edge_y1 <= on_wire.y1;
					last_edge <= on_wire.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each result against the oldest verdict.
	always @(posedge clk) begin : check_results
		verdict_t v;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				flag_mismatch("result with no verdict pending");
			end else begin
				v = verdicts_due.pop_front();
				if (inside_res !== v.odd)
					flag_mismatch($sformatf("inside_res %0b, want %0b", inside_res, v.odd));
				if (any_crossing !== v.hit)
					flag_mismatch($sformatf("any_crossing %0b, want %0b", any_crossing, v.hit));
				if (min_distance !== v.dist_val)
					flag_mismatch($sformatf("min_distance %h, want %h", min_distance,
						v.dist_val));
			end
		end
	end

	initial begin
		// square, point inside
		add_edge(5, 5, 0, 0, 10, 0, 0);
		add_edge(5, 5, 10, 0, 10, 10, 0);
		add_edge(5, 5, 10, 10, 0, 10, 0);
		add_edge(5, 5, 0, 10, 0, 0, 1);
		// same square, point to the right: crossings lie left
		add_edge(100, 5, 0, 0, 10, 0, 0);
		add_edge(100, 5, 10, 0, 10, 10, 0);
		add_edge(100, 5, 10, 10, 0, 10, 0);
		add_edge(100, 5, 0, 10, 0, 0, 1);
		// crossing exactly at the point
		add_edge(5, 5, 5, 0, 5, 10, 1);
		// vertices on the ray and a horizontal edge along it
		add_edge(0, 0, 10, -10, 10, 0, 0);
		add_edge(0, 0, 10, 0, 30, 0, 0);
		add_edge(0, 0, 30, 0, 20, 10, 0);
		add_edge(0, 0, 20, 10, 10, -10, 1);
		// widest distance, still a crossing
		add_edge(C_MIN, 0, C_MAX, C_MIN, C_MAX, C_MAX, 1);
		// vertex at top of range lifted past it
		add_edge(C_MIN, C_MAX, 0, C_MAX, 5, C_MIN, 1);
		add_edge(C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, 1);
		// full-range diagonal
		add_edge(-1, -1, C_MIN, C_MAX, C_MAX, C_MIN, 1);
		// edge wholly above, and a point-sized edge on the ray
		add_edge(0, 0, 0, 5, 9, 7, 1);
		add_edge(0, 0, 5, 0, 5, 0, 1);
		while (edge_reqs.size() < ITEMS) begin
			if ($urandom_range(99) < 85)
				add_polygon();
			else
				add_noise();
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (edge_reqs.size() != 0 || in_valid)
			@(negedge clk);
		while (verdicts_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (errors == 0)
			$display("PASS point_in_polygon_ray_cast_core");
		else
			$display("FAIL point_in_polygon_ray_cast_core");
		$finish;
	end

endmodule
